/* rtl/tcpt_pkg.sv */
package tcpt_pkg;

  // event kinds carried in the input tuser
  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_NEW_ACK = 2'd1,
    EV_DUP_ACK = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  // connection phase codes
  localparam logic [1:0] PHASE_CLOSED = 2'd0;
  localparam logic [1:0] PHASE_OPEN   = 2'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_SEG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_INIT_WIN  = 2'd1;
  localparam logic [1:0] CFG_DUP_THR   = 2'd2;
  localparam logic [1:0] CFG_INIT_SSTH = 2'd3;

  // reset values
  localparam logic [15:0] SEG_SIZE_RST  = 16'd536;
  localparam logic [4:0]  INIT_WIN_RST  = 5'd1;
  localparam logic [7:0]  DUP_THR_RST   = 8'd3;
  localparam logic [31:0] INIT_SSTH_RST = 32'd65535;

  // serial divider
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // controller state, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_DIV    = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_step;
    logic update;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

/* rtl/tcpt_ctrl.sv */
module tcpt_ctrl
  import tcpt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic out_tready,
  output logic out_tvalid,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // sequencing of one transaction
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? S_DIV : S_UPDATE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/tcpt_dpath.sv */
module tcpt_dpath
  import tcpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  mode,
  input  logic [15:0] dup_count,
  input  logic [31:0] receiver_window,
  input  logic [1:0]  conn_phase,
  input  logic        all_data_acked,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] congestion_window,
  output logic [31:0] slow_start_threshold,
  output logic [31:0] send_window,
  output logic        retransmit_request
);

  logic [15:0] seg_r;
  logic [4:0]  iw_r;
  logic [7:0]  dup_thr_r;
  logic [31:0] init_ss_r;

  logic [31:0] cwnd_r, cwnd_nxt;
  logic [31:0] ssth_r, ssth_nxt;
  logic        retx_r, retx_nxt;

  event_t      mode_r;
  logic [15:0] dup_cnt_r;
  logic [31:0] rwnd_r;
  logic [1:0]  phase_r;
  logic        acked_r;

  logic        slow_r;
  logic [20:0] init_win_r;
  logic [31:0] quot_r;
  logic [32:0] rem_r;

  logic [31:0] cw_out_r, ss_out_r, sw_out_r;
  logic        retx_out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= SEG_SIZE_RST;
      iw_r      <= INIT_WIN_RST;
      dup_thr_r <= DUP_THR_RST;
      init_ss_r <= INIT_SSTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SEG_SIZE:  seg_r     <= cfg_wdata[15:0];
        CFG_INIT_WIN:  iw_r      <= cfg_wdata[4:0];
        CFG_DUP_THR:   dup_thr_r <= cfg_wdata[7:0];
        CFG_INIT_SSTH: init_ss_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r    <= event_t'(mode);
      dup_cnt_r <= dup_count;
      rwnd_r    <= receiver_window;
      phase_r   <= conn_phase;
      acked_r   <= all_data_acked;
    end
  end

  // products and slow start decision
  logic        in_slow;
  logic [31:0] seg_sq;
  logic [20:0] init_win;

  assign in_slow      = (cwnd_r < ssth_r);
  assign seg_sq       = {16'b0, seg_r} * {16'b0, seg_r};
  assign init_win     = {16'b0, iw_r} * {5'b0, seg_r};
  assign sts.need_div = (mode_r == EV_NEW_ACK) && !in_slow;

  // restoring divider, one quotient bit per step; divisor zero gives all ones
  logic [32:0] rem_shift;
  logic        rem_ge;

  assign rem_shift = {rem_r[31:0], quot_r[31]};
  assign rem_ge    = (rem_shift >= {1'b0, cwnd_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      slow_r     <= in_slow;
      init_win_r <= init_win;
      quot_r     <= seg_sq;
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[30:0], rem_ge};
      rem_r  <= rem_ge ? (rem_shift - {1'b0, cwnd_r}) : rem_shift;
    end
  end

  // window and threshold update
  logic [31:0] inc;
  logic [32:0] sum;
  logic [31:0] sat_sum;
  logic [31:0] half_cwnd;
  logic [31:0] two_seg;
  logic [31:0] cut_ssth;
  logic        skip_to;

  assign inc       = slow_r ? {16'b0, seg_r} : ((quot_r == '0) ? 32'd1 : quot_r);
  assign sum       = {1'b0, cwnd_r} + {1'b0, inc};
  assign sat_sum   = sum[32] ? '1 : sum[31:0];
  assign half_cwnd = {1'b0, cwnd_r[31:1]};
  assign two_seg   = {15'b0, seg_r, 1'b0};
  assign cut_ssth  = (half_cwnd > two_seg) ? half_cwnd : two_seg;
  assign skip_to   = (phase_r == PHASE_CLOSED) || ((phase_r == PHASE_OPEN) && acked_r);

  always_comb begin
    cwnd_nxt = cwnd_r;
    ssth_nxt = ssth_r;
    retx_nxt = 1'b0;
    case (mode_r)
      EV_START: begin
        cwnd_nxt = {11'b0, init_win_r};
        ssth_nxt = init_ss_r;
      end
      EV_NEW_ACK: begin
        cwnd_nxt = sat_sum;
      end
      EV_DUP_ACK: begin
        if (dup_cnt_r == {8'b0, dup_thr_r}) begin
          cwnd_nxt = {16'b0, seg_r};
          ssth_nxt = cut_ssth;
          retx_nxt = 1'b1;
        end
      end
      EV_TIMEOUT: begin
        if (!skip_to) begin
          cwnd_nxt = {16'b0, seg_r};
          ssth_nxt = cut_ssth;
          retx_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwnd_r <= '0;
      ssth_r <= INIT_SSTH_RST;
    end else if (cmd.update) begin
      cwnd_r <= cwnd_nxt;
      ssth_r <= ssth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      retx_r <= retx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cw_out_r   <= cwnd_r;
      ss_out_r   <= ssth_r;
      sw_out_r   <= (rwnd_r < cwnd_r) ? rwnd_r : cwnd_r;
      retx_out_r <= retx_r;
    end
  end

  assign congestion_window    = cw_out_r;
  assign slow_start_threshold = ss_out_r;
  assign send_window          = sw_out_r;
  assign retransmit_request   = retx_out_r;

endmodule

/* rtl/tcp_tahoe_cwnd_update.sv */
// TCP Tahoe congestion window update.
// Input stream: one transaction per event. in_tuser carries the event kind
// (start, new ack, duplicate ack, timeout); in_tdata carries the duplicate
// count, receiver window, connection phase and all-acked flag.
// Output stream: one transaction per event with the new congestion window,
// slow start threshold, send window and a retransmit request flag.
// Configuration: cfg_we/cfg_addr/cfg_wdata write segment size, initial
// window, duplicate ack threshold and initial threshold; write only while idle.
// Sequencing: one event at a time. A congestion avoidance ack
// runs the 32-step serial divider for floor(seg*seg/cwnd) before the
// update; every other event goes straight to the update.
// The next event is accepted only after the result is loaded.
// Reset clears the window to zero, loads the threshold and the configuration
// registers with their defaults and empties the output register.
// When the receiver stalls, the result stays in the output register and the
// block accepts and computes one more event, then holds it until the
// register frees up.
module tcp_tahoe_cwnd_update
  import tcpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // dup_count, receiver_window, conn_phase, all_data_acked
  input  logic [1:0]   in_tuser,   // mode
  // output stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // congestion_window, slow_start_threshold,
                                   // send_window, retransmit_request
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] congestion_window;
  logic [31:0] slow_start_threshold;
  logic [31:0] send_window;
  logic        retransmit_request;

  tcpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  tcpt_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .mode                 (in_tuser),
    .dup_count            (in_tdata[15:0]),
    .receiver_window      (in_tdata[47:16]),
    .conn_phase           (in_tdata[49:48]),
    .all_data_acked       (in_tdata[50]),
    .cmd                  (cmd),
    .sts                  (sts),
    .congestion_window    (congestion_window),
    .slow_start_threshold (slow_start_threshold),
    .send_window          (send_window),
    .retransmit_request   (retransmit_request)
  );

  // pack the result transaction
  assign out_tdata = {7'b0, retransmit_request, send_window,
                      slow_start_threshold, congestion_window};

endmodule

/* rtl/tcpt_chk.sv */
module tcpt_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one event in flight: no acceptance right after an acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // send window never exceeds the congestion window
  a_send_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:64] <= out_tdata[31:0])
    else $error("send window above congestion window");

  // after a retransmit the threshold is at least two windows of one segment
  a_retx_ssth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[96] |-> {1'b0, out_tdata[63:32]} >= {out_tdata[31:0], 1'b0})
    else $error("threshold below two segments on retransmit");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tcp_tahoe_cwnd_update tcpt_chk u_tcpt_chk (.*);

/* tb/sv/tb_tcp_tahoe_cwnd_update.sv */
module tb_tcp_tahoe_cwnd_update;
  import tcpt_pkg::*;

  // phase codes the package leaves unnamed
  localparam logic [1:0] PHASE_CLOSING = 2'd2;
  localparam logic [1:0] PHASE_SPARE   = 2'd3;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 200;

  typedef struct {
    event_t      kind;
    logic [15:0] dup_count;
    logic [31:0] rwnd;
    logic [1:0]  phase;
    logic        acked;
  } tcp_event_t;

  typedef struct {
    logic [31:0] cwnd;
    logic [31:0] ssth;
    logic [31:0] snd_wnd;
    logic        retx;
  } window_result_t;

  // shadow of the congestion state plus the queue of pending windows
  class tahoe_window_scoreboard;
    logic [15:0] seg;
    logic [4:0]  init_win;
    logic [7:0]  dup_thr;
    logic [31:0] init_ssth;
    logic [31:0] cwnd;
    logic [31:0] ssth;
    window_result_t expected_windows[$];
    int mismatch_count;

    function new();
      seg            = SEG_SIZE_RST;
      init_win       = INIT_WIN_RST;
      dup_thr        = DUP_THR_RST;
      init_ssth      = INIT_SSTH_RST;
      cwnd           = '0;
      ssth           = INIT_SSTH_RST;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_SEG_SIZE:  seg = val[15:0];
        CFG_INIT_WIN:  init_win = val[4:0];
        CFG_DUP_THR:   dup_thr = val[7:0];
        CFG_INIT_SSTH: init_ssth = val;
        default: ;
      endcase
    endfunction

    // advance the window state for one accepted event
    function void note_event(tcp_event_t ev);
      logic [32:0] total;
      logic [31:0] sq;
      logic [31:0] inc;
      logic [31:0] half;
      logic [31:0] two_seg;
      window_result_t res;
      res.retx = 1'b0;
      case (ev.kind)
        EV_START: begin
          cwnd = {27'd0, init_win} * {16'd0, seg};
          ssth = init_ssth;
        end
        EV_NEW_ACK: begin
          if (cwnd < ssth) begin
            inc = {16'd0, seg};
          end else if (cwnd == 32'd0) begin
            inc = '1;
          end else begin
            sq  = {16'd0, seg} * {16'd0, seg};
            inc = sq / cwnd;
            if (inc == 32'd0) inc = 32'd1;
          end
          total = {1'b0, cwnd} + {1'b0, inc};
          cwnd  = total[32] ? '1 : total[31:0];
        end
        EV_DUP_ACK: begin
          res.retx = (ev.dup_count == {8'd0, dup_thr});
        end
        default: begin
          res.retx = !(ev.phase == PHASE_CLOSED || (ev.phase == PHASE_OPEN && ev.acked));
        end
      endcase
      // retransmit: threshold to half the window with a two-segment floor, window to one segment
      if (res.retx) begin
        half    = cwnd >> 1;
        two_seg = {15'd0, seg, 1'b0};
        ssth    = (half > two_seg) ? half : two_seg;
        cwnd    = {16'd0, seg};
      end
      res.cwnd    = cwnd;
      res.ssth    = ssth;
      res.snd_wnd = (ev.rwnd < cwnd) ? ev.rwnd : cwnd;
      expected_windows.push_back(res);
    endfunction

    function void report_field(string fld, logic [31:0] exp_v, logic [31:0] act_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, exp_v, act_v);
    endfunction

    function void check_window(logic [103:0] data);
      window_result_t exp_r;
      if (expected_windows.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      exp_r = expected_windows.pop_front();
      if (data[31:0] !== exp_r.cwnd)
        report_field("congestion_window", exp_r.cwnd, data[31:0]);
      if (data[63:32] !== exp_r.ssth)
        report_field("slow_start_threshold", exp_r.ssth, data[63:32]);
      if (data[95:64] !== exp_r.snd_wnd)
        report_field("send_window", exp_r.snd_wnd, data[95:64]);
      if (data[96] !== exp_r.retx)
        report_field("retransmit_request", {31'd0, exp_r.retx}, {31'd0, data[96]});
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [55:0]  in_tdata = '0;   // dup_count, receiver_window, conn_phase, all_data_acked
  logic [1:0]   in_tuser = '0;   // mode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;       // congestion_window, slow_start_threshold,
                                 // send_window, retransmit_request

  tahoe_window_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  tcp_tahoe_cwnd_update u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check each transaction, random stalls, one long hold-off
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_window(out_tdata);
    if (hold_left == 0 && hold_armed && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic tcp_event_t mk_event(event_t kind, logic [15:0] dup, logic [31:0] rwnd,
                                          logic [1:0] phase, logic acked);
    tcp_event_t ev;
    ev.kind      = kind;
    ev.dup_count = dup;
    ev.rwnd      = rwnd;
    ev.phase     = phase;
    ev.acked     = acked;
    return ev;
  endfunction

  // offer one event, with random idle cycles ahead of it
  task automatic send_event(tcp_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev.kind;
    in_tdata  <= {5'd0, ev.acked, ev.phase, ev.rwnd, ev.dup_count};
    do @(posedge clk); while (!in_tready);
    sb.note_event(ev);
  endtask

  // drop valid and let every pending result come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] seg, logic [4:0] win, logic [7:0] thr,
                            logic [31:0] ssth);
    logic [31:0] vals[4];
    vals[0] = {16'd0, seg};
    vals[1] = {27'd0, win};
    vals[2] = {24'd0, thr};
    vals[3] = ssth;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.write_reg(i[1:0], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed traffic around the current window, some pure noise
  function automatic tcp_event_t pick_event();
    tcp_event_t ev;
    int r;
    ev.dup_count = 16'($urandom_range(65535));
    ev.phase     = 2'($urandom_range(3));
    ev.acked     = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: ev.rwnd = $urandom();
      1: ev.rwnd = sb.cwnd + $urandom_range(64) - 32;
      2: ev.rwnd = $urandom_range(200000);
      default: ev.rwnd = $urandom_range(1) ? '1 : '0;
    endcase
    if ($urandom_range(9) == 0) begin
      ev.kind = event_t'($urandom_range(3));
      return ev;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      ev.kind = EV_START;
    end else if (r < 68) begin
      ev.kind = EV_NEW_ACK;
    end else if (r < 88) begin
      ev.kind = EV_DUP_ACK;
      if ($urandom_range(99) < 50) ev.dup_count = {8'd0, sb.dup_thr};
      else ev.dup_count = 16'($urandom_range(sb.dup_thr + 2));
    end else begin
      ev.kind = EV_TIMEOUT;
    end
    return ev;
  endfunction

  initial begin
    logic [15:0] seg;
    logic [7:0]  thr;
    logic [31:0] ssth;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: ack before any start, retransmit paths, ignored timeouts
    send_event(mk_event(EV_NEW_ACK, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_DUP_ACK, 16'd3, '0, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_START, 16'hffff, 32'd1000, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, 32'd700, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_DUP_ACK, 16'd2, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_TIMEOUT, 16'd0, '1, PHASE_CLOSED, 1'b0));
    send_event(mk_event(EV_TIMEOUT, 16'd0, '1, PHASE_OPEN, 1'b1));
    send_event(mk_event(EV_TIMEOUT, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_TIMEOUT, 16'd0, '1, PHASE_CLOSING, 1'b1));
    send_event(mk_event(EV_TIMEOUT, 16'd0, '1, PHASE_SPARE, 1'b1));
    drain();

    // all-zero settings: zero window in avoidance, saturation, zero segment
    set_config(16'd0, 5'd0, 8'd0, 32'd0);
    send_event(mk_event(EV_START, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, 32'hfffffffe, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_DUP_ACK, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_TIMEOUT, 16'd0, '0, PHASE_SPARE, 1'b0));
    drain();

    // largest segment, duplicate threshold and initial threshold settings; initial window of 16
    set_config(16'hffff, 5'd16, 8'd255, '1);
    send_event(mk_event(EV_START, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_DUP_ACK, 16'd254, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_DUP_ACK, 16'd255, '1, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_NEW_ACK, 16'd0, 32'd5, PHASE_OPEN, 1'b0));
    send_event(mk_event(EV_TIMEOUT, 16'hffff, '1, PHASE_OPEN, 1'b0));
    drain();

    // random phases, each with fresh settings and its own idle pattern
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(4))
        0: seg = 16'($urandom_range(1, 16));
        1: seg = 16'hffff;
        2: seg = 16'($urandom_range(1, 65535));
        3: seg = SEG_SIZE_RST;
        default: seg = 16'($urandom_range(17, 2000));
      endcase
      case ($urandom_range(2))
        0: thr = 8'($urandom_range(1, 8));
        1: thr = 8'($urandom_range(1, 255));
        default: thr = 8'd255;
      endcase
      case ($urandom_range(3))
        0: ssth = $urandom();
        1: ssth = {16'd0, seg} * $urandom_range(1, 64);
        2: ssth = '1;
        default: ssth = '0;
      endcase
      set_config(seg, 5'($urandom_range(1, 16)), thr, ssth);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      // long receiver hold-off while the sender keeps pushing
      if (p == 4) hold_armed = 1'b1;
      send_event(mk_event(EV_START, 16'($urandom_range(65535)), $urandom(),
                          2'($urandom_range(3)), 1'($urandom_range(1))));
      for (int i = 1; i < PHASE_ITEMS; i++) send_event(pick_event());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
